@@ rtl/lec_pkg.sv @@
// shared types, constants and codes of the line ending converter
`timescale 1ns / 1ps

package lec_pkg;

  localparam int LineCountWidthDefault = 32;
  localparam int QueueDepthDefault     = 2;
  localparam int MaxResults            = 8;
  localparam int ResIdxWidth           = $clog2(MaxResults);
  localparam int ResCntWidth           = $clog2(MaxResults + 1);
  localparam int LineOutWidth          = 32;
  localparam int CfgAddrWidth          = 4;
  localparam int CfgDataWidth          = 32;

  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharQuote = 8'h22;

  localparam logic KindData = 1'b0;
  localparam logic KindEnd  = 1'b1;

  typedef enum logic [2:0] {
    StRunning     = 3'd0,
    StDone        = 3'd1,
    StCrInLf      = 3'd2,
    StLfNoCr      = 3'd3,
    StNoLfAfterCr = 3'd4,
    StEndAfterCr  = 3'd5,
    StEndInQuotes = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    RegToLfOnly        = 2'd0,
    RegBomHandling     = 2'd1,
    RegKeepQuotedBreak = 2'd2,
    RegNoFinalNewline  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic to_lf_only;
    logic bom_handling;
    logic keep_quoted_breaks;
    logic no_final_newline;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
  } entry_t;

  // one request's worth of results, handed from front to back
  typedef struct packed {
    entry_t [MaxResults-1:0]  ent;
    logic [ResIdxWidth-1:0]   last_idx;
    status_t                  status;
    logic [LineOutWidth-1:0]  line;
  } desc_t;

  function automatic logic [7:0] bom_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'hEF;
      2'd1:    b = 8'hBB;
      2'd2:    b = 8'hBF;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/lec_cfg_regs.sv @@
// configuration register bank behind the apb-style port
`timescale 1ns / 1ps

module lec_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lec_pkg::CfgAddrWidth-1:0] paddr,
  input  logic [lec_pkg::CfgDataWidth-1:0] pwdata,
  output logic [lec_pkg::CfgDataWidth-1:0] prdata,
  output logic                            pready,
  output lec_pkg::cfg_t                   cfg
);
  import lec_pkg::*;

  reg_idx_t idx;
  logic     wr_en;
  logic     rd_bit;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.to_lf_only         <= 1'b1;
      cfg.bom_handling       <= 1'b1;
      cfg.keep_quoted_breaks <= 1'b0;
      cfg.no_final_newline   <= 1'b0;
    end else if (wr_en) begin
      case (idx)
        RegToLfOnly:        cfg.to_lf_only         <= pwdata[0];
        RegBomHandling:     cfg.bom_handling       <= pwdata[0];
        RegKeepQuotedBreak: cfg.keep_quoted_breaks <= pwdata[0];
        RegNoFinalNewline:  cfg.no_final_newline   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegToLfOnly:        rd_bit = cfg.to_lf_only;
      RegBomHandling:     rd_bit = cfg.bom_handling;
      RegKeepQuotedBreak: rd_bit = cfg.keep_quoted_breaks;
      RegNoFinalNewline:  rd_bit = cfg.no_final_newline;
      default:            rd_bit = 1'b0;
    endcase
  end

  assign prdata = {{(CfgDataWidth-1){1'b0}}, rd_bit};

endmodule

@@ rtl/lec_front.sv @@
// front end: stream state, byte classification and result list building
`timescale 1ns / 1ps

module lec_front #(
  parameter int LINE_COUNT_WIDTH = lec_pkg::LineCountWidthDefault
) (
  input  logic           clk,
  input  logic           rst,
  input  lec_pkg::cfg_t  cfg,
  input  logic           acc,
  input  logic           kind,
  input  logic [7:0]     in_byte,
  output logic           q_push,
  output lec_pkg::desc_t q_desc
);
  import lec_pkg::*;

  localparam int WideW = (LINE_COUNT_WIDTH > LineOutWidth) ? LINE_COUNT_WIDTH
                                                            : LineOutWidth + 1;

  // stream state
  logic [1:0]                  hm, hm_next;
  logic                        hp, hp_next;
  logic                        inq, inq_next;
  logic                        pcr, pcr_next;
  logic                        nt, nt_next;
  logic                        failed, failed_next;
  status_t                     fcode, fcode_next;
  logic [LINE_COUNT_WIDTH-1:0] lc, lc_next, lc_inc, lc_show;

  entry_t [MaxResults-1:0]     ent;
  logic [ResCntWidth-1:0]      n;
  status_t                     st;
  logic                        quoted;
  logic                        body;
  logic [WideW-1:0]            lc_wide;

  assign lc_inc = (lc == '1) ? lc : lc + LINE_COUNT_WIDTH'(1);

  always_comb begin
    hm_next     = hm;
    hp_next     = hp;
    inq_next    = inq;
    pcr_next    = pcr;
    nt_next     = nt;
    failed_next = failed;
    fcode_next  = fcode;
    lc_next     = lc;
    ent         = '0;
    n           = '0;
    st          = StRunning;
    body        = 1'b0;
    quoted      = cfg.keep_quoted_breaks && inq;

    if (kind == KindEnd) begin
      if (failed) begin
        st = fcode;
        n  = n + 1'b1;
      end else if (hp) begin
        for (int i = 0; i < 3; i++) begin
          if (2'(i) < hm) begin
            ent[n[ResIdxWidth-1:0]] = '{data: bom_byte(2'(i)), has: 1'b1};
            n = n + 1'b1;
          end
        end
        st = StDone;
        n  = n + 1'b1;
      end else if (pcr) begin
        st = StEndAfterCr;
        n  = n + 1'b1;
      end else if (quoted) begin
        st = StEndInQuotes;
        n  = n + 1'b1;
      end else begin
        if (!cfg.no_final_newline && nt) begin
          if (!cfg.to_lf_only) begin
            ent[n[ResIdxWidth-1:0]] = '{data: CharCr, has: 1'b1};
            n = n + 1'b1;
          end
          ent[n[ResIdxWidth-1:0]] = '{data: CharLf, has: 1'b1};
          n = n + 1'b1;
        end
        st = StDone;
        n  = n + 1'b1;
      end
    end else if (!failed) begin
      if (hp) begin
        if (hm != 2'd3 && in_byte == bom_byte(hm)) begin
          hm_next = hm + 2'd1;
          if (hm == 2'd2) begin
            hp_next = 1'b0;
            if (!(cfg.to_lf_only && cfg.bom_handling)) begin
              for (int i = 0; i < 3; i++) begin
                ent[n[ResIdxWidth-1:0]] = '{data: bom_byte(2'(i)), has: 1'b1};
                n = n + 1'b1;
              end
              nt_next = 1'b1;
            end
          end
        end else begin
          // header mismatch: optional bom, replay of matched bytes, then the byte
          hp_next = 1'b0;
          if (!cfg.to_lf_only && cfg.bom_handling) begin
            for (int i = 0; i < 3; i++) begin
              ent[n[ResIdxWidth-1:0]] = '{data: bom_byte(2'(i)), has: 1'b1};
              n = n + 1'b1;
            end
            nt_next = 1'b1;
          end
          for (int i = 0; i < 3; i++) begin
            if (2'(i) < hm) begin
              ent[n[ResIdxWidth-1:0]] = '{data: bom_byte(2'(i)), has: 1'b1};
              n = n + 1'b1;
              nt_next = 1'b1;
            end
          end
          body = 1'b1;
        end
      end else begin
        body = 1'b1;
      end

      if (body) begin
        if (pcr) begin
          if (in_byte != CharLf) begin
            st          = StNoLfAfterCr;
            n           = n + 1'b1;
            failed_next = 1'b1;
            fcode_next  = StNoLfAfterCr;
          end else begin
            pcr_next = 1'b0;
            ent[n[ResIdxWidth-1:0]] = '{data: CharLf, has: 1'b1};
            n       = n + 1'b1;
            nt_next = 1'b0;
            lc_next = lc_inc;
          end
        end else if (in_byte == CharQuote) begin
          inq_next = !inq;
          ent[n[ResIdxWidth-1:0]] = '{data: in_byte, has: 1'b1};
          n       = n + 1'b1;
          nt_next = 1'b1;
        end else if (in_byte == CharCr) begin
          if (quoted) begin
            ent[n[ResIdxWidth-1:0]] = '{data: in_byte, has: 1'b1};
            n       = n + 1'b1;
            nt_next = 1'b1;
          end else if (!cfg.to_lf_only) begin
            st          = StCrInLf;
            n           = n + 1'b1;
            failed_next = 1'b1;
            fcode_next  = StCrInLf;
          end else begin
            pcr_next = 1'b1;
          end
        end else if (in_byte == CharLf) begin
          if (quoted) begin
            ent[n[ResIdxWidth-1:0]] = '{data: in_byte, has: 1'b1};
            n       = n + 1'b1;
            nt_next = 1'b0;
          end else if (cfg.to_lf_only) begin
            st          = StLfNoCr;
            n           = n + 1'b1;
            failed_next = 1'b1;
            fcode_next  = StLfNoCr;
          end else begin
            ent[n[ResIdxWidth-1:0]] = '{data: CharCr, has: 1'b1};
            n = n + 1'b1;
            ent[n[ResIdxWidth-1:0]] = '{data: CharLf, has: 1'b1};
            n       = n + 1'b1;
            nt_next = 1'b0;
            lc_next = lc_inc;
          end
        end else begin
          ent[n[ResIdxWidth-1:0]] = '{data: in_byte, has: 1'b1};
          n       = n + 1'b1;
          nt_next = 1'b1;
        end
      end
    end
  end

  // line number shown with this request's results, saturated to the port width
  assign lc_show = (kind == KindEnd) ? lc : lc_next;
  assign lc_wide = WideW'(lc_show);

  always_comb begin
    q_desc.ent      = ent;
    q_desc.last_idx = ResIdxWidth'(n - 1'b1);
    q_desc.status   = st;
    q_desc.line     = (lc_wide[WideW-1:LineOutWidth] != '0) ? '1
                                                           : lc_wide[LineOutWidth-1:0];
  end

  assign q_push = acc && (n != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      hm     <= 2'd0;
      hp     <= 1'b1;
      inq    <= 1'b0;
      pcr    <= 1'b0;
      nt     <= 1'b1;
      failed <= 1'b0;
      fcode  <= StRunning;
      lc     <= LINE_COUNT_WIDTH'(1);
    end else if (acc) begin
      if (kind == KindEnd) begin
        hm     <= 2'd0;
        hp     <= 1'b1;
        inq    <= 1'b0;
        pcr    <= 1'b0;
        nt     <= 1'b1;
        failed <= 1'b0;
        fcode  <= StRunning;
        lc     <= LINE_COUNT_WIDTH'(1);
      end else begin
        hm     <= hm_next;
        hp     <= hp_next;
        inq    <= inq_next;
        pcr    <= pcr_next;
        nt     <= nt_next;
        failed <= failed_next;
        fcode  <= fcode_next;
        lc     <= lc_next;
      end
    end
  end

endmodule

@@ rtl/lec_queue.sv @@
// short request queue between front and back
`timescale 1ns / 1ps

module lec_queue #(
  parameter int QUEUE_DEPTH = lec_pkg::QueueDepthDefault
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lec_pkg::desc_t wdata,
  output logic           full,
  input  logic           pop,
  output lec_pkg::desc_t rdata,
  output logic           empty
);
  import lec_pkg::*;

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  desc_t            slots [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr, rd_ptr;
  logic [CntW-1:0]  count;
  logic             do_push, do_pop;

  assign full    = (count == CntW'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/lec_back.sv @@
// back end: holds one request and hands out its results one per pop
`timescale 1ns / 1ps

module lec_back (
  input  logic           clk,
  input  logic           rst,
  input  lec_pkg::desc_t q_data,
  input  logic           q_empty,
  output logic           q_pop,
  output logic [7:0]     out_byte,
  output logic           has_byte,
  output logic [2:0]     status,
  output logic [31:0]    line_number,
  output logic           last,
  output logic           empty,
  input  logic           pop
);
  import lec_pkg::*;

  desc_t                  cur;
  logic                   cur_valid;
  logic [ResIdxWidth-1:0] idx;
  logic                   take;
  logic                   at_last;
  entry_t                 e;

  assign at_last = (idx == cur.last_idx);
  assign take    = cur_valid && pop;
  assign q_pop   = !q_empty && (!cur_valid || (take && at_last));

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (take && !at_last) begin
        idx <= idx + 1'b1;
      end else if (take || q_pop) begin
        idx <= '0;
      end
      if (q_pop) begin
        cur_valid <= 1'b1;
      end else if (take && at_last) begin
        cur_valid <= 1'b0;
      end
    end
  end

  assign e           = cur.ent[idx];
  assign out_byte    = e.data;
  assign has_byte    = e.has;
  assign status      = e.has ? StRunning : cur.status;
  assign line_number = cur.line;
  assign last        = at_last;
  assign empty       = !cur_valid;

endmodule

@@ rtl/line_ending_converter_unit.sv @@
// top level of the crlf / lf line ending converter with utf-8 bom handling
//
//   channel   handshake          payload
//   input     push / full        kind, in_byte
//   results   pop / empty        out_byte, has_byte, status, line_number, last
//   config    psel/penable/...   paddr (byte address 4*index), pwdata, prdata
//
// the front takes one request per cycle while full is low and turns it into
// a list of up to eight results in the same cycle; the back hands them out
// one per pop. a request yielding n results holds the back for n pops, so
// while pop is held high byte-for-byte traffic runs at one request per cycle
// and bursts (bom, replay, crlf) drain at one result per cycle; full rises
// only when the request queue is full; requests that yield nothing (matched
// bom bytes, held cr, dropped bytes after an error) never enter the queue
// reset is synchronous and returns registers and the stream to their start
`timescale 1ns / 1ps

module line_ending_converter_unit #(
  parameter int LINE_COUNT_WIDTH = lec_pkg::LineCountWidthDefault,
  parameter int QUEUE_DEPTH      = lec_pkg::QueueDepthDefault
) (
  input  logic                             clk,
  input  logic                             rst,
  // input side
  input  logic                             push,
  output logic                             full,
  input  logic                             kind,
  input  logic [7:0]                       in_byte,
  // result side
  input  logic                             pop,
  output logic                             empty,
  output logic [7:0]                       out_byte,
  output logic                             has_byte,
  output logic [2:0]                       status,
  output logic [31:0]                      line_number,
  output logic                             last,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lec_pkg::CfgAddrWidth-1:0] paddr,
  input  logic [lec_pkg::CfgDataWidth-1:0] pwdata,
  output logic [lec_pkg::CfgDataWidth-1:0] prdata,
  output logic                             pready
);
  import lec_pkg::*;

  cfg_t  cfg;
  logic  acc;
  logic  q_push, q_full, q_pop, q_empty;
  desc_t q_wdata, q_rdata;

  // a request is taken whenever the queue has room
  assign full = q_full;
  assign acc  = push && !q_full;

  lec_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // stream state and classification
  lec_front #(
    .LINE_COUNT_WIDTH (LINE_COUNT_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .acc     (acc),
    .kind    (kind),
    .in_byte (in_byte),
    .q_push  (q_push),
    .q_desc  (q_wdata)
  );

  // decouples the front from stalls on the result side
  lec_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // result sequencing
  lec_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_data      (q_rdata),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .out_byte    (out_byte),
    .has_byte    (has_byte),
    .status      (status),
    .line_number (line_number),
    .last        (last),
    .empty       (empty),
    .pop         (pop)
  );

endmodule
